// File: rtl/slcd_pkg.sv
// ----------------------------------------------------------------------------
// Sprite line command decoder package
// Parser phases, result codes, stream constants and the parser state record.
// ----------------------------------------------------------------------------
package slcd_pkg;

  parameter int unsigned MaxLines    = 1024;
  parameter int unsigned HeaderBytes = 18;

  localparam logic [11:0] ColMax = 12'hFFF;

  localparam logic [7:0] MarkLine  = 8'h01;
  localparam logic [7:0] MarkEmpty = 8'h02;

  localparam logic [7:0] CmdNop  = 8'h00;
  localparam logic [7:0] CmdEnd  = 8'h02;
  localparam logic [7:0] CmdSkip = 8'h03;
  localparam logic [7:0] CmdRun  = 8'h04;

  typedef enum logic [2:0] {
    PH_HALT,
    PH_HEADER,
    PH_LEN,
    PH_MARK,
    PH_ARG,
    PH_CMD,
    PH_PIX,
    PH_DONEP
  } phase_e;

  typedef enum logic [1:0] {
    KIND_PIXEL,
    KIND_DONE,
    KIND_ERROR
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE,
    ERR_MARKER,
    ERR_END_EARLY,
    ERR_UNKNOWN_CMD
  } err_e;

  typedef struct packed {
    phase_e      phase;
    logic [9:0]  line_number;
    logic [7:0]  line_length;
    logic [9:0]  line_offset;
    logic [7:0]  held_argument;
    logic [7:0]  run_remaining;
    logic        run_was_odd;
    logic [11:0] column;
  } state_t;

  typedef struct packed {
    kind_e       kind;
    logic [11:0] x_pos;
    logic [9:0]  y_pos;
    logic [7:0]  color_index;
    err_e        error_code;
  } result_t;

  // Number of lines actually parsed for a given frame height.
  function automatic logic [9:0] lines_used(input logic [9:0] height);
    if (32'(height) < MaxLines - 1) begin
      return height;
    end
    return 10'(MaxLines - 1);
  endfunction

endpackage

// File: rtl/slcd_step.sv
// ----------------------------------------------------------------------------
// Sprite line command decoder step logic
// Next parser state and the optional result word for one stream byte.
// ----------------------------------------------------------------------------
module slcd_step (
  input  slcd_pkg::state_t  cur_i,
  input  logic [7:0]        data_byte_i,
  input  logic              frame_start_i,
  input  logic [9:0]        lines_i,
  output slcd_pkg::state_t  nxt_o,
  output logic              emit_o,
  output slcd_pkg::result_t res_o
);

  slcd_pkg::state_t  nxt;
  slcd_pkg::result_t res;
  logic              emit;
  logic              do_done;
  logic              do_fail;
  slcd_pkg::err_e    fail_code;
  logic              do_finish;
  logic              do_end;
  logic              fin_emit;
  logic [9:0]        hdr_off;
  logic [9:0]        off_inc;
  logic [9:0]        ln_next;
  logic [12:0]       col_sum;
  logic [7:0]        rem_dec;

  always_comb begin
    nxt       = cur_i;
    emit      = 1'b0;
    do_done   = 1'b0;
    do_fail   = 1'b0;
    fail_code = slcd_pkg::ERR_NONE;
    do_finish = 1'b0;
    do_end    = 1'b0;
    fin_emit  = 1'b0;
    res       = '{kind: slcd_pkg::KIND_PIXEL, x_pos: '0, y_pos: '0,
                  color_index: '0, error_code: slcd_pkg::ERR_NONE};

    hdr_off = (frame_start_i ? 10'd0 : cur_i.line_offset) + 10'd1;
    off_inc = cur_i.line_offset + 10'd1;
    ln_next = cur_i.line_number + 10'd1;
    col_sum = {1'b0, cur_i.column} + {5'd0, cur_i.held_argument};
    rem_dec = cur_i.run_remaining - 8'd1;

    if (frame_start_i || cur_i.phase == slcd_pkg::PH_HEADER) begin
      if (frame_start_i) begin
        nxt       = '0;
        nxt.phase = slcd_pkg::PH_HEADER;
      end
      nxt.line_offset = hdr_off;
      if (32'(hdr_off) >= slcd_pkg::HeaderBytes) begin
        nxt.line_offset = '0;
        if (lines_i == 10'd0) begin
          do_done = 1'b1;
        end else begin
          nxt.phase = slcd_pkg::PH_LEN;
        end
      end
    end else begin
      unique case (cur_i.phase)
        slcd_pkg::PH_LEN: begin
          nxt.line_length = data_byte_i;
          nxt.phase       = slcd_pkg::PH_MARK;
        end
        slcd_pkg::PH_MARK: begin
          if (data_byte_i != slcd_pkg::MarkLine &&
              !(data_byte_i == slcd_pkg::MarkEmpty && cur_i.line_length == 8'd0)) begin
            do_fail   = 1'b1;
            fail_code = slcd_pkg::ERR_MARKER;
          end else begin
            nxt.column      = '0;
            nxt.line_offset = '0;
            if (cur_i.line_length == 8'd0) begin
              do_end = 1'b1;
            end else begin
              nxt.phase = slcd_pkg::PH_ARG;
            end
          end
        end
        slcd_pkg::PH_ARG: begin
          nxt.held_argument = data_byte_i;
          nxt.line_offset   = off_inc;
          nxt.phase         = slcd_pkg::PH_CMD;
        end
        slcd_pkg::PH_CMD: begin
          nxt.line_offset = off_inc;
          unique case (data_byte_i)
            slcd_pkg::CmdNop: begin
              do_finish = 1'b1;
            end
            slcd_pkg::CmdEnd: begin
              if ({1'b0, cur_i.line_number} + 11'd1 != {1'b0, lines_i}) begin
                do_fail   = 1'b1;
                fail_code = slcd_pkg::ERR_END_EARLY;
              end else begin
                do_finish = 1'b1;
              end
            end
            slcd_pkg::CmdSkip: begin
              nxt.column = col_sum[12] ? slcd_pkg::ColMax : col_sum[11:0];
              do_finish  = 1'b1;
            end
            slcd_pkg::CmdRun: begin
              nxt.run_remaining = cur_i.held_argument;
              nxt.run_was_odd   = cur_i.held_argument[0];
              if (cur_i.held_argument == 8'd0) begin
                do_finish = 1'b1;
              end else begin
                nxt.phase = slcd_pkg::PH_PIX;
              end
            end
            default: begin
              do_fail   = 1'b1;
              fail_code = slcd_pkg::ERR_UNKNOWN_CMD;
            end
          endcase
        end
        slcd_pkg::PH_PIX: begin
          nxt.line_offset = off_inc;
          if (cur_i.run_remaining != 8'd0) begin
            emit            = 1'b1;
            res.kind        = slcd_pkg::KIND_PIXEL;
            res.x_pos       = cur_i.column;
            res.y_pos       = cur_i.line_number;
            res.color_index = data_byte_i;
            if (cur_i.column < slcd_pkg::ColMax) begin
              nxt.column = cur_i.column + 12'd1;
            end
            nxt.run_remaining = rem_dec;
            if (rem_dec == 8'd0 && !cur_i.run_was_odd) begin
              do_finish = 1'b1;
              fin_emit  = 1'b1;
            end
          end else begin
            nxt.run_was_odd = 1'b0;
            do_finish       = 1'b1;
          end
        end
        slcd_pkg::PH_DONEP: begin
          do_done = 1'b1;
        end
        default: begin
        end
      endcase
    end

    if (do_finish) begin
      if (nxt.line_offset >= {2'b00, cur_i.line_length}) begin
        do_end = 1'b1;
      end else begin
        nxt.phase = slcd_pkg::PH_ARG;
      end
    end

    if (do_end) begin
      nxt.line_number = ln_next;
      if (ln_next >= lines_i) begin
        if (fin_emit) begin
          nxt.phase = slcd_pkg::PH_DONEP;
        end else begin
          do_done = 1'b1;
        end
      end else begin
        nxt.phase = slcd_pkg::PH_LEN;
      end
    end

    if (do_fail) begin
      emit           = 1'b1;
      res.kind       = slcd_pkg::KIND_ERROR;
      res.x_pos      = cur_i.column;
      res.y_pos      = cur_i.line_number;
      res.error_code = fail_code;
      nxt.phase      = slcd_pkg::PH_HALT;
    end

    if (do_done) begin
      emit      = 1'b1;
      res       = '{kind: slcd_pkg::KIND_DONE, x_pos: '0, y_pos: '0,
                    color_index: '0, error_code: slcd_pkg::ERR_NONE};
      nxt.phase = slcd_pkg::PH_HALT;
    end
  end

  assign nxt_o  = nxt;
  assign emit_o = emit;
  assign res_o  = res;

endmodule

// File: rtl/slcd_out_reg.sv
// ----------------------------------------------------------------------------
// Sprite line command decoder result register
// Holds one result word until the consumer takes it.
// ----------------------------------------------------------------------------
module slcd_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  slcd_pkg::result_t res_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output slcd_pkg::result_t res_o
);

  logic              valid_q;
  logic              valid_d;
  slcd_pkg::result_t res_q;

  always_comb begin
    valid_d = valid_q & ~out_ready_i;
    if (load_i) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

// File: rtl/sprite_line_command_decoder.sv
// ----------------------------------------------------------------------------
// Sprite line command decoder
// Parses a row-coded sprite byte stream into pixel, done and error words.
//
//   Channel  Direction  Handshake                Payload
//   cfg      in         cfg_valid_i/cfg_ready_o  cfg_frame_height_i
//   in       in         in_valid_i/in_ready_o    data_byte_i, frame_start_i
//   out      out        out_valid_o/out_ready_i  kind, x_pos, y_pos, color, error
//
// One byte is accepted per cycle when in_ready_o is high; results are registered.
// The input is ready whenever the result register is empty or being drained.
// After reset the parser is halted until a byte with frame_start arrives.
// Configuration writes are always accepted.
// ----------------------------------------------------------------------------
module sprite_line_command_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [9:0]  cfg_frame_height_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        frame_start_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [11:0] x_pos_o,
  output logic [9:0]  y_pos_o,
  output logic [7:0]  color_index_o,
  output logic [1:0]  error_code_o
);

  logic              accept;
  logic [9:0]        frame_height_q;
  slcd_pkg::state_t  state_q;
  slcd_pkg::state_t  state_d;
  logic              emit;
  slcd_pkg::result_t step_res;
  slcd_pkg::result_t out_res;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = ~out_valid_o | out_ready_i;
  assign accept      = in_valid_i & in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_height_q <= 10'd1;
    end else if (cfg_valid_i) begin
      frame_height_q <= cfg_frame_height_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{phase: slcd_pkg::PH_HALT, default: '0};
    end else if (accept) begin
      state_q <= state_d;
    end
  end

  slcd_step u_step (
    .cur_i         (state_q),
    .data_byte_i   (data_byte_i),
    .frame_start_i (frame_start_i),
    .lines_i       (slcd_pkg::lines_used(frame_height_q)),
    .nxt_o         (state_d),
    .emit_o        (emit),
    .res_o         (step_res)
  );

  slcd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept & emit),
    .res_i       (step_res),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .res_o       (out_res)
  );

  assign kind_o        = out_res.kind;
  assign x_pos_o       = out_res.x_pos;
  assign y_pos_o       = out_res.y_pos;
  assign color_index_o = out_res.color_index;
  assign error_code_o  = out_res.error_code;

endmodule

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// Sprite line command decoder testbench
// Streams directed and random sprite frames through the decoder, predicts
// every pixel, done and error word, and compares each output word in order.
// ----------------------------------------------------------------------------
module testbench;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
  } stream_byte_t;

  typedef enum int {
    FLAW_NONE,
    FLAW_EARLY_END,
    FLAW_BAD_CMD,
    FLAW_BAD_MARK
  } flaw_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [9:0]  cfg_frame_height_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i = '0;
  logic        frame_start_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  kind_o;
  logic [11:0] x_pos_o;
  logic [9:0]  y_pos_o;
  logic [7:0]  color_index_o;
  logic [1:0]  error_code_o;

  stream_byte_t      pending_bytes[$];
  stream_byte_t      offered_byte;
  slcd_pkg::result_t expected_words[$];
  int unsigned       queued_count = 0;
  int unsigned       fail_count = 0;
  int unsigned       send_idle_pct = 0;
  int unsigned       recv_idle_pct = 0;
  int unsigned       hold_left = 0;
  bit                hold_armed = 1'b0;
  bit                hold_used = 1'b0;

  logic [9:0]       frame_height;
  slcd_pkg::phase_e parse_phase;
  logic [9:0]       line_num;
  logic [7:0]       line_len;
  logic [9:0]       body_offset;
  logic [7:0]       held_arg;
  logic [7:0]       run_left;
  logic             run_odd;
  logic [11:0]      column_pos;

  sprite_line_command_decoder dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_frame_height_i (cfg_frame_height_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .data_byte_i        (data_byte_i),
    .frame_start_i      (frame_start_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .kind_o             (kind_o),
    .x_pos_o            (x_pos_o),
    .y_pos_o            (y_pos_o),
    .color_index_o      (color_index_o),
    .error_code_o       (error_code_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [9:0] lines_in_frame();
    return (frame_height > 10'(slcd_pkg::MaxLines - 1)) ?
           10'(slcd_pkg::MaxLines - 1) : frame_height;
  endfunction

  function automatic void push_word(input slcd_pkg::kind_e k, input logic [11:0] x,
                                    input logic [9:0] y, input logic [7:0] c,
                                    input slcd_pkg::err_e e);
    slcd_pkg::result_t w;
    w.kind = k;
    w.x_pos = x;
    w.y_pos = y;
    w.color_index = c;
    w.error_code = e;
    expected_words.push_back(w);
  endfunction

  function automatic void raise_error(input slcd_pkg::err_e code);
    push_word(slcd_pkg::KIND_ERROR, column_pos, line_num, 8'h00, code);
    parse_phase = slcd_pkg::PH_HALT;
  endfunction

  function automatic void report_done();
    push_word(slcd_pkg::KIND_DONE, 12'd0, 10'd0, 8'h00, slcd_pkg::ERR_NONE);
    parse_phase = slcd_pkg::PH_HALT;
  endfunction

  function automatic void close_line(input bit emitted);
    line_num = line_num + 10'd1;
    if (line_num >= lines_in_frame()) begin
      if (emitted) begin
        parse_phase = slcd_pkg::PH_DONEP;
      end else begin
        report_done();
      end
    end else begin
      parse_phase = slcd_pkg::PH_LEN;
    end
  endfunction

  function automatic void close_cmd(input bit emitted);
    if (body_offset >= {2'b00, line_len}) begin
      close_line(emitted);
    end else begin
      parse_phase = slcd_pkg::PH_ARG;
    end
  endfunction

  function automatic void count_header();
    body_offset = body_offset + 10'd1;
    if (body_offset >= 10'(slcd_pkg::HeaderBytes)) begin
      body_offset = '0;
      if (lines_in_frame() == 10'd0) begin
        report_done();
      end else begin
        parse_phase = slcd_pkg::PH_LEN;
      end
    end
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input logic start);
    logic [12:0] sum;
    if (start) begin
      line_num = '0;
      line_len = '0;
      body_offset = '0;
      held_arg = '0;
      run_left = '0;
      run_odd = 1'b0;
      column_pos = '0;
      parse_phase = slcd_pkg::PH_HEADER;
      count_header();
      return;
    end
    case (parse_phase)
      slcd_pkg::PH_HEADER: begin
        count_header();
      end
      slcd_pkg::PH_LEN: begin
        line_len = b;
        parse_phase = slcd_pkg::PH_MARK;
      end
      slcd_pkg::PH_MARK: begin
        if (b != slcd_pkg::MarkLine &&
            !(b == slcd_pkg::MarkEmpty && line_len == 8'd0)) begin
          raise_error(slcd_pkg::ERR_MARKER);
        end else begin
          column_pos = '0;
          body_offset = '0;
          if (line_len == 8'd0) begin
            close_line(1'b0);
          end else begin
            parse_phase = slcd_pkg::PH_ARG;
          end
        end
      end
      slcd_pkg::PH_ARG: begin
        held_arg = b;
        body_offset = body_offset + 10'd1;
        parse_phase = slcd_pkg::PH_CMD;
      end
      slcd_pkg::PH_CMD: begin
        body_offset = body_offset + 10'd1;
        case (b)
          slcd_pkg::CmdNop: begin
            close_cmd(1'b0);
          end
          slcd_pkg::CmdEnd: begin
            if ({1'b0, line_num} + 11'd1 != {1'b0, lines_in_frame()}) begin
              raise_error(slcd_pkg::ERR_END_EARLY);
            end else begin
              close_cmd(1'b0);
            end
          end
          slcd_pkg::CmdSkip: begin
            sum = {1'b0, column_pos} + {5'b0, held_arg};
            column_pos = (sum > {1'b0, slcd_pkg::ColMax}) ? slcd_pkg::ColMax : sum[11:0];
            close_cmd(1'b0);
          end
          slcd_pkg::CmdRun: begin
            run_left = held_arg;
            run_odd = held_arg[0];
            if (run_left == 8'd0) begin
              close_cmd(1'b0);
            end else begin
              parse_phase = slcd_pkg::PH_PIX;
            end
          end
          default: begin
            raise_error(slcd_pkg::ERR_UNKNOWN_CMD);
          end
        endcase
      end
      slcd_pkg::PH_PIX: begin
        body_offset = body_offset + 10'd1;
        if (run_left != 8'd0) begin
          push_word(slcd_pkg::KIND_PIXEL, column_pos, line_num, b, slcd_pkg::ERR_NONE);
          if (column_pos < slcd_pkg::ColMax) begin
            column_pos = column_pos + 12'd1;
          end
          run_left = run_left - 8'd1;
          if (run_left == 8'd0 && !run_odd) begin
            close_cmd(1'b1);
          end
        end else begin
          run_odd = 1'b0;
          close_cmd(1'b0);
        end
      end
      slcd_pkg::PH_DONEP: begin
        report_done();
      end
      default: begin
      end
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    if (fail_count < 100) begin
      $display("%0t: mismatch: %s", $time, msg);
    end
    fail_count++;
  endtask

  task automatic check_word();
    slcd_pkg::result_t want;
    if (expected_words.size() == 0) begin
      report_mismatch($sformatf("word with no expectation: kind %0d x %0d y %0d",
                                kind_o, x_pos_o, y_pos_o));
      return;
    end
    want = expected_words.pop_front();
    if (kind_o !== want.kind) begin
      report_mismatch($sformatf("kind %0d, expected %0d", kind_o, want.kind));
    end
    if (x_pos_o !== want.x_pos) begin
      report_mismatch($sformatf("x_pos %0d, expected %0d", x_pos_o, want.x_pos));
    end
    if (y_pos_o !== want.y_pos) begin
      report_mismatch($sformatf("y_pos %0d, expected %0d", y_pos_o, want.y_pos));
    end
    if (color_index_o !== want.color_index) begin
      report_mismatch($sformatf("color_index %0d, expected %0d", color_index_o,
                                want.color_index));
    end
    if (error_code_o !== want.error_code) begin
      report_mismatch($sformatf("error_code %0d, expected %0d", error_code_o,
                                want.error_code));
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        decode_byte(data_byte_i, frame_start_i);
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          offered_byte = pending_bytes.pop_front();
          in_valid_i <= 1'b1;
          data_byte_i <= offered_byte.data;
          frame_start_i <= offered_byte.start;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        check_word();
      end
      out_ready_i <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_armed && !hold_used) begin
      hold_left <= 400;
      hold_used <= 1'b1;
    end
  end

  task automatic add_byte(input logic [7:0] b, input logic start);
    stream_byte_t s;
    s.data = b;
    s.start = start;
    pending_bytes.push_back(s);
    queued_count++;
  endtask

  task automatic add_data(input logic [7:0] b);
    add_byte(b, 1'b0);
  endtask

  task automatic add_header();
    add_byte(8'($urandom), 1'b1);
    repeat (slcd_pkg::HeaderBytes - 1) add_data(8'($urandom));
  endtask

  task automatic add_line(input bit last, input flaw_e flaw);
    logic [7:0] body[$];
    logic [7:0] marker;
    int unsigned n, roll, prev_end, len;
    bit ends_in_run;
    if (flaw == FLAW_NONE && $urandom_range(7) == 0) begin
      add_data(8'h00);
      add_data($urandom_range(1) ? slcd_pkg::MarkEmpty : slcd_pkg::MarkLine);
      return;
    end
    prev_end = 0;
    ends_in_run = 1'b0;
    repeat ($urandom_range(1, 4)) begin
      if (body.size() < 150) begin
        prev_end = body.size();
        ends_in_run = 1'b0;
        roll = $urandom_range(9);
        if (roll < 2) begin
          body.push_back(8'($urandom));
          body.push_back(slcd_pkg::CmdNop);
        end else if (roll < 4) begin
          body.push_back(($urandom_range(3) == 0) ? 8'd255 : 8'($urandom));
          body.push_back(slcd_pkg::CmdSkip);
        end else begin
          n = ($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(5);
          body.push_back(8'(n));
          body.push_back(slcd_pkg::CmdRun);
          repeat (n) body.push_back(8'($urandom));
          if (n % 2 == 1) begin
            body.push_back(8'($urandom));
          end
          ends_in_run = 1'b1;
        end
      end
    end
    if (flaw == FLAW_EARLY_END || (last && $urandom_range(2) == 0)) begin
      prev_end = body.size();
      ends_in_run = 1'b0;
      body.push_back(8'($urandom));
      body.push_back(slcd_pkg::CmdEnd);
    end
    if (flaw == FLAW_BAD_CMD) begin
      body.push_back(8'($urandom));
      body.push_back(($urandom_range(3) == 0) ? 8'h01 : 8'($urandom_range(5, 255)));
    end
    len = body.size();
    if (ends_in_run && flaw == FLAW_NONE && $urandom_range(3) == 0) begin
      len = $urandom_range(prev_end + 1, body.size());
    end
    marker = slcd_pkg::MarkLine;
    if (flaw == FLAW_BAD_MARK) begin
      marker = $urandom_range(1) ? 8'h00 : 8'($urandom_range(2, 255));
    end
    add_data(8'(len));
    add_data(marker);
    foreach (body[i]) add_data(body[i]);
  endtask

  task automatic add_frame(input int unsigned lines, input flaw_e flaw,
                           input int unsigned empty_lines);
    int unsigned flaw_line;
    flaw_line = lines;
    if (flaw == FLAW_EARLY_END && lines > 1) begin
      flaw_line = $urandom_range(lines - 2);
    end else if (lines > 0) begin
      flaw_line = $urandom_range(lines - 1);
    end
    add_header();
    for (int unsigned i = 0; i < lines; i++) begin
      if (i < empty_lines) begin
        add_data(8'h00);
        add_data($urandom_range(1) ? slcd_pkg::MarkEmpty : slcd_pkg::MarkLine);
      end else begin
        add_line(i == lines - 1, (i == flaw_line) ? flaw : FLAW_NONE);
      end
    end
    add_data(8'($urandom));
  endtask

  task automatic add_random_frames(input int unsigned target);
    int unsigned stop_at, lines, roll;
    lines = lines_in_frame();
    stop_at = queued_count + target;
    while (queued_count < stop_at) begin
      roll = $urandom_range(19);
      if (roll < 15) begin
        add_frame(lines, FLAW_NONE, 0);
      end else if (roll == 15) begin
        add_frame(lines, (lines > 1) ? FLAW_EARLY_END : FLAW_BAD_CMD, 0);
      end else if (roll == 16) begin
        add_frame(lines, FLAW_BAD_CMD, 0);
      end else if (roll == 17) begin
        add_frame(lines, FLAW_BAD_MARK, 0);
      end else if (roll == 18) begin
        add_header();
        repeat ($urandom_range(20)) add_data(8'($urandom));
      end else begin
        repeat ($urandom_range(1, 20)) add_byte(8'($urandom), $urandom_range(7) == 0);
      end
    end
  endtask

  task automatic write_height(input logic [9:0] h);
    cfg_valid_i <= 1'b1;
    cfg_frame_height_i <= h;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    frame_height = h;
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_bytes.size() != 0 || in_valid_i || expected_words.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    frame_height = 10'd1;
    parse_phase = slcd_pkg::PH_HALT;
    line_num = '0;
    line_len = '0;
    body_offset = '0;
    held_arg = '0;
    run_left = '0;
    run_odd = 1'b0;
    column_pos = '0;
    send_idle_pct = 14;
    recv_idle_pct = 68;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_height(10'd0);
    add_data(8'h5A);
    add_data(8'hA5);
    add_header();
    add_byte(8'hFF, 1'b1);
    repeat (5) add_data(8'($urandom));
    add_header();
    add_data(8'h00);
    wait_idle();

    write_height(10'd1);
    add_header();
    add_data(8'd14);
    add_data(slcd_pkg::MarkLine);
    add_data(8'd3);
    add_data(slcd_pkg::CmdRun);
    add_data(8'h00);
    add_data(8'hFF);
    add_data(8'h5A);
    add_data(8'hC3);
    add_data(8'd7);
    add_data(slcd_pkg::CmdNop);
    add_data(8'hAB);
    add_data(slcd_pkg::CmdEnd);
    add_data(8'd2);
    add_data(slcd_pkg::CmdRun);
    add_data(8'h11);
    add_data(8'hEE);
    add_data(8'h3C);
    add_header();
    add_data(8'd35);
    add_data(slcd_pkg::MarkLine);
    repeat (17) begin
      add_data(8'd255);
      add_data(slcd_pkg::CmdSkip);
    end
    add_data(8'd2);
    add_data(slcd_pkg::CmdRun);
    add_data(8'h77);
    add_data(8'h88);
    add_data(8'h96);
    wait_idle();

    write_height(10'd2);
    add_header();
    add_data(8'd4);
    add_data(slcd_pkg::MarkEmpty);
    add_data(8'h00);
    add_header();
    add_data(8'd4);
    add_data(slcd_pkg::MarkLine);
    add_data(8'd9);
    add_data(slcd_pkg::CmdSkip);
    add_data(8'h00);
    add_data(slcd_pkg::CmdEnd);
    add_header();
    add_data(8'd0);
    add_data(slcd_pkg::MarkEmpty);
    add_data(8'd2);
    add_data(slcd_pkg::MarkLine);
    add_data(8'd1);
    add_data(8'h05);
    add_random_frames(150);
    wait_idle();

    send_idle_pct = 68;
    recv_idle_pct = 14;
    write_height(10'd3);
    add_random_frames(150);
    wait_idle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_height(10'd1023);
    add_frame(6, FLAW_NONE, 3);
    wait_idle();

    write_height(10'($urandom_range(1, 6)));
    hold_armed = 1'b1;
    add_random_frames(100);
    wait_idle();

    if (fail_count == 0) begin
      $display("[sprite_line_command_decoder] OK");
    end else begin
      $display("[sprite_line_command_decoder] ERROR");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("[sprite_line_command_decoder] ERROR");
    $finish;
  end

endmodule

// File: sim.f
rtl/slcd_pkg.sv
rtl/slcd_step.sv
rtl/slcd_out_reg.sv
rtl/sprite_line_command_decoder.sv
tb/sv/testbench.sv
